>>> rtl/rmdq_pkg.sv
// Shared types, widths and constants of the matrix to dual quaternion converter.
package rmdq_pkg;

    // Word and fixed-point geometry.
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned FRAC_W   = 30;
    localparam int unsigned LANE_W   = 33;
    localparam int unsigned ARG_W    = 33;
    localparam int unsigned NORM_MIN = 10;

    // Component positions inside a quaternion.
    localparam int unsigned IDX_X = 0;
    localparam int unsigned IDX_Y = 1;
    localparam int unsigned IDX_Z = 2;
    localparam int unsigned IDX_W = 3;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [LANE_W-1:0] lane_t;

    localparam word_t Q30_ONE = 32'sh4000_0000;
    localparam word_t SAT_POS = 32'sh7FFF_FFFF;
    localparam word_t SAT_NEG = 32'sh8000_0000;

    // Which quaternion component carries the square root term.
    typedef enum logic [1:0] {
        BR_X = 2'd0,
        BR_Y = 2'd1,
        BR_Z = 2'd2,
        BR_W = 2'd3
    } branch_t;

    typedef struct packed {
        word_t rot_00;
        word_t rot_10;
        word_t rot_20;
        word_t rot_01;
        word_t rot_11;
        word_t rot_21;
        word_t rot_02;
        word_t rot_12;
        word_t rot_22;
        word_t trans_x;
        word_t trans_y;
        word_t trans_z;
    } xform_t;

    typedef struct packed {
        word_t real_x;
        word_t real_y;
        word_t real_z;
        word_t real_w;
        word_t dual_x;
        word_t dual_y;
        word_t dual_z;
        word_t dual_w;
    } dquat_t;

    typedef struct packed {
        word_t x;
        word_t y;
        word_t z;
    } trans_t;

    // Data that rides beside the first square root.
    typedef struct packed {
        branch_t         branch;
        lane_t [2:0]     lane;
        trans_t          trans;
    } front_side_t;

endpackage

>>> rtl/rmdq_if.sv
// Valid/ready channel interfaces for transforms in and dual quaternions out.
interface rmdq_xform_if;
    import rmdq_pkg::*;

    logic   valid;
    logic   ready;
    xform_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rmdq_dquat_if;
    import rmdq_pkg::*;

    logic   valid;
    logic   ready;
    dquat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/rigid_matrix_to_dual_quaternion.sv
// Top level: rigid joint transform to unit dual quaternion, fully pipelined.
//
// Channels: xform carries one transform (nine Q2.30 rotation entries and a
// Q16.16 translation) per transaction; dquat returns one dual quaternion per
// transaction (real part Q2.30, dual part Q16.16). Both use valid/ready.
// Throughput: one transaction per cycle while the receiver takes results.
// Stages: the front stage, two 32-stage square roots, two 32-stage dividers
// and six single stages of assembly, squaring, summing, normalizing and the
// dual product; each root and quotient bit has a register stage of its own.
// The whole pipeline advances together: ready on xform is high whenever the
// output register is empty or being taken. When the receiver stalls, every
// stage holds, nothing is lost or repeated, and the result stays on dquat.
// Reset clears all valid bits; data registers are not reset.
module rigid_matrix_to_dual_quaternion (
    input  logic          clk,
    input  logic          rst_n,
    rmdq_xform_if.sink    xform,
    rmdq_dquat_if.source  dquat
);
    import rmdq_pkg::*;

    localparam int unsigned RAD_W   = 2 * WORD_W;
    localparam int unsigned ROOT_W  = WORD_W;
    localparam int unsigned DEN1_W  = ROOT_W + 1;
    localparam int unsigned MAG2_W  = WORD_W - 1;
    localparam int unsigned SQ_W    = 2 * WORD_W - 2;
    localparam int unsigned PROD_W  = 2 * WORD_W;

    typedef struct packed {
        branch_t               branch;
        logic [2:0]            neg;
        logic                  zero;
        logic [WORD_W-2:0]     diag;
        trans_t                trans;
    } div1_side_t;

    typedef struct packed {
        word_t [3:0]           q;
        trans_t                trans;
    } norm_side_t;

    typedef struct packed {
        logic [3:0]            neg;
        logic                  ident;
        trans_t                trans;
    } div2_side_t;

    logic                          en;

    logic                          fr_valid;
    logic [ARG_W-1:0]              fr_arg;
    front_side_t                   fr_side;

    logic                          s1_valid;
    logic [ROOT_W-1:0]             s1_root;
    front_side_t                   s1_side;

    logic [2:0][LANE_W-1:0]        mag1;
    div1_side_t                    d1_side_in;
    logic                          d1_valid;
    logic [2:0][WORD_W-1:0]        d1_quot;
    div1_side_t                    d1_side;

    word_t [2:0]                   lane_val;
    word_t                         diag_val;
    norm_side_t                    asm_next;
    logic                          asm_valid_reg;
    norm_side_t                    asm_reg;

    logic [3:0][SQ_W-1:0]          sq_next;
    logic                          sq_valid_reg;
    logic [3:0][SQ_W-1:0]          sq_reg;
    norm_side_t                    sq_side_reg;

    logic [RAD_W-1:0]              n2_next;
    logic                          sum_valid_reg;
    logic [RAD_W-1:0]              n2_reg;
    norm_side_t                    sum_side_reg;

    logic                          s2_valid;
    logic [ROOT_W-1:0]             s2_root;
    norm_side_t                    s2_side;

    logic [3:0][MAG2_W-1:0]        mag2;
    div2_side_t                    d2_side_in;
    logic                          d2_valid;
    logic [3:0][WORD_W-1:0]        d2_quot;
    div2_side_t                    d2_side;

    word_t [3:0]                   real_next;
    logic                          real_valid_reg;
    word_t [3:0]                   real_reg;
    trans_t                        real_trans_reg;

    // Pipeline advance: the output register is empty or being taken.
    assign en          = !dquat.valid || dquat.ready;
    assign xform.ready = en;

    rmdq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (xform.valid),
        .in_data   (xform.data),
        .out_valid (fr_valid),
        .out_arg   (fr_arg),
        .out_side  (fr_side)
    );

    // Root of the argument in Q.30; s is twice this root.
    rmdq_sqrt_pipe #(
        .RAD_W  (RAD_W),
        .SIDE_W ($bits(front_side_t))
    ) u_sqrt_rot (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fr_valid),
        .in_rad    (RAD_W'({fr_arg, {FRAC_W{1'b0}}})),
        .in_side   (fr_side),
        .out_valid (s1_valid),
        .out_root  (s1_root),
        .out_side  (s1_side)
    );

    // Lane magnitudes and signs for the divisions by s.
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            d1_side_in.neg[l] = s1_side.lane[l][LANE_W-1];
            mag1[l] = d1_side_in.neg[l] ? LANE_W'(-s1_side.lane[l])
                                        : LANE_W'(s1_side.lane[l]);
        end
        d1_side_in.branch = s1_side.branch;
        d1_side_in.zero   = (s1_root == '0);
        d1_side_in.diag   = s1_root[ROOT_W-1:1];
        d1_side_in.trans  = s1_side.trans;
    end

    rmdq_div_pipe #(
        .LANES  (3),
        .MAG_W  (LANE_W),
        .DEN_W  (DEN1_W),
        .SIDE_W ($bits(div1_side_t))
    ) u_div_rot (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s1_valid),
        .in_mag    (mag1),
        .in_den    ({s1_root, 1'b0}),
        .in_side   (d1_side_in),
        .out_valid (d1_valid),
        .out_quot  (d1_quot),
        .out_side  (d1_side)
    );

    // Signed, saturated lane terms placed around the root term.
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (d1_side.zero) begin
                lane_val[l] = '0;
            end
            else if (d1_quot[l][WORD_W-1]) begin
                lane_val[l] = d1_side.neg[l] ? -SAT_POS : SAT_POS;
            end
            else begin
                lane_val[l] = d1_side.neg[l] ? -word_t'({1'b0, d1_quot[l][WORD_W-2:0]})
                                             : word_t'({1'b0, d1_quot[l][WORD_W-2:0]});
            end
        end
        diag_val       = word_t'({1'b0, d1_side.diag});
        asm_next.trans = d1_side.trans;
        case (d1_side.branch)
            BR_X:    asm_next.q = {lane_val[2], lane_val[1], lane_val[0], diag_val};
            BR_Y:    asm_next.q = {lane_val[2], lane_val[1], diag_val, lane_val[0]};
            BR_Z:    asm_next.q = {lane_val[2], diag_val, lane_val[1], lane_val[0]};
            BR_W:    asm_next.q = {diag_val, lane_val[2], lane_val[1], lane_val[0]};
            default: asm_next.q = {diag_val, lane_val[2], lane_val[1], lane_val[0]};
        endcase
    end

    // Squares of the four terms.
    always_comb begin
        logic signed [PROD_W-1:0] sq;
        for (int i = 0; i < 4; i++) begin
            sq         = PROD_W'(asm_reg.q[i]) * PROD_W'(asm_reg.q[i]);
            sq_next[i] = sq[SQ_W-1:0];
        end
    end

    // Squared norm in Q.60.
    assign n2_next = RAD_W'(sq_reg[0]) + RAD_W'(sq_reg[1])
                   + RAD_W'(sq_reg[2]) + RAD_W'(sq_reg[3]);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            asm_valid_reg  <= 1'b0;
            sq_valid_reg   <= 1'b0;
            sum_valid_reg  <= 1'b0;
            real_valid_reg <= 1'b0;
        end
        else if (en) begin
            asm_valid_reg  <= d1_valid;
            sq_valid_reg   <= asm_valid_reg;
            sum_valid_reg  <= sq_valid_reg;
            real_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            asm_reg        <= asm_next;
            sq_reg         <= sq_next;
            sq_side_reg    <= asm_reg;
            n2_reg         <= n2_next;
            sum_side_reg   <= sq_side_reg;
            real_reg       <= real_next;
            real_trans_reg <= d2_side.trans;
        end
    end

    // Norm in Q.30.
    rmdq_sqrt_pipe #(
        .RAD_W  (RAD_W),
        .SIDE_W ($bits(norm_side_t))
    ) u_sqrt_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sum_valid_reg),
        .in_rad    (n2_reg),
        .in_side   (sum_side_reg),
        .out_valid (s2_valid),
        .out_root  (s2_root),
        .out_side  (s2_side)
    );

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            d2_side_in.neg[i] = s2_side.q[i][WORD_W-1];
            mag2[i] = d2_side_in.neg[i] ? MAG2_W'(-s2_side.q[i]) : MAG2_W'(s2_side.q[i]);
        end
        d2_side_in.ident = (s2_root <= ROOT_W'(NORM_MIN));
        d2_side_in.trans = s2_side.trans;
    end

    rmdq_div_pipe #(
        .LANES  (4),
        .MAG_W  (MAG2_W),
        .DEN_W  (ROOT_W),
        .SIDE_W ($bits(div2_side_t))
    ) u_div_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s2_valid),
        .in_mag    (mag2),
        .in_den    (s2_root),
        .in_side   (d2_side_in),
        .out_valid (d2_valid),
        .out_quot  (d2_quot),
        .out_side  (d2_side)
    );

    // Normalized real part, or the identity when the norm is tiny.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (d2_side.ident) begin
                real_next[i] = (i == IDX_W) ? Q30_ONE : '0;
            end
            else if (d2_quot[i][WORD_W-1]) begin
                real_next[i] = d2_side.neg[i] ? SAT_NEG : SAT_POS;
            end
            else begin
                real_next[i] = d2_side.neg[i] ? -word_t'({1'b0, d2_quot[i][WORD_W-2:0]})
                                              : word_t'({1'b0, d2_quot[i][WORD_W-2:0]});
            end
        end
    end

    rmdq_dual u_dual (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (real_valid_reg),
        .in_real   (real_reg),
        .in_trans  (real_trans_reg),
        .out_valid (dquat.valid),
        .out_data  (dquat.data)
    );

endmodule

>>> rtl/rmdq_front.sv
// Front stage: Shepperd branch choice, root argument and off-diagonal sums and differences.
module rmdq_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  rmdq_pkg::xform_t              in_data,
    output logic                          out_valid,
    output logic [rmdq_pkg::ARG_W-1:0]    out_arg,
    output rmdq_pkg::front_side_t         out_side
);
    import rmdq_pkg::*;

    localparam int unsigned TRACE_W = WORD_W + 2;
    localparam int unsigned ARGS_W  = WORD_W + 3;

    logic signed [TRACE_W-1:0] trace;
    logic signed [ARGS_W-1:0]  arg_x;
    logic signed [ARGS_W-1:0]  arg_y;
    logic signed [ARGS_W-1:0]  arg_z;
    logic signed [ARGS_W-1:0]  arg_w;
    logic signed [ARGS_W-1:0]  arg_sel;
    lane_t                     dzy;
    lane_t                     dxz;
    lane_t                     dyx;
    lane_t                     sxy;
    lane_t                     sxz;
    lane_t                     syz;
    branch_t                   branch;
    logic [ARG_W-1:0]          arg_next;
    front_side_t               side_next;
    logic                      valid_reg;
    logic [ARG_W-1:0]          arg_reg;
    front_side_t               side_reg;

    // Trace and the four candidate root arguments.
    assign trace = TRACE_W'(in_data.rot_00) + TRACE_W'(in_data.rot_11)
                 + TRACE_W'(in_data.rot_22);
    assign arg_w = ARGS_W'(Q30_ONE) + ARGS_W'(trace);
    assign arg_x = ARGS_W'(Q30_ONE) + ARGS_W'(in_data.rot_00)
                 - ARGS_W'(in_data.rot_11) - ARGS_W'(in_data.rot_22);
    assign arg_y = ARGS_W'(Q30_ONE) + ARGS_W'(in_data.rot_11)
                 - ARGS_W'(in_data.rot_00) - ARGS_W'(in_data.rot_22);
    assign arg_z = ARGS_W'(Q30_ONE) + ARGS_W'(in_data.rot_22)
                 - ARGS_W'(in_data.rot_00) - ARGS_W'(in_data.rot_11);

    // Off-diagonal differences and sums.
    assign dzy = LANE_W'(in_data.rot_21) - LANE_W'(in_data.rot_12);
    assign dxz = LANE_W'(in_data.rot_02) - LANE_W'(in_data.rot_20);
    assign dyx = LANE_W'(in_data.rot_10) - LANE_W'(in_data.rot_01);
    assign sxy = LANE_W'(in_data.rot_01) + LANE_W'(in_data.rot_10);
    assign sxz = LANE_W'(in_data.rot_02) + LANE_W'(in_data.rot_20);
    assign syz = LANE_W'(in_data.rot_12) + LANE_W'(in_data.rot_21);

    // Branch on positive trace, then on the largest diagonal entry.
    always_comb begin
        if (!trace[TRACE_W-1] && (trace != '0)) begin
            branch = BR_W;
        end
        else if ((in_data.rot_00 > in_data.rot_11) && (in_data.rot_00 > in_data.rot_22)) begin
            branch = BR_X;
        end
        else if (in_data.rot_11 > in_data.rot_22) begin
            branch = BR_Y;
        end
        else begin
            branch = BR_Z;
        end
    end

    // Lanes hold the three divided terms in component order, skipping the root term.
    always_comb begin
        side_next.branch = branch;
        side_next.trans  = '{x: in_data.trans_x, y: in_data.trans_y, z: in_data.trans_z};
        case (branch)
            BR_X:
            begin
                arg_sel        = arg_x;
                side_next.lane = {dzy, sxz, sxy};
            end
            BR_Y:
            begin
                arg_sel        = arg_y;
                side_next.lane = {dxz, syz, sxy};
            end
            BR_Z:
            begin
                arg_sel        = arg_z;
                side_next.lane = {dyx, syz, sxz};
            end
            BR_W:
            begin
                arg_sel        = arg_w;
                side_next.lane = {dyx, dxz, dzy};
            end
            default:
            begin
                arg_sel        = arg_w;
                side_next.lane = {dyx, dxz, dzy};
            end
        endcase
        arg_next = arg_sel[ARGS_W-1] ? '0 : arg_sel[ARG_W-1:0];
    end

    // Stage register.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            arg_reg  <= arg_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_arg   = arg_reg;
    assign out_side  = side_reg;

endmodule

>>> rtl/rmdq_sqrt_pipe.sv
// Pipelined integer square root, one root bit per register stage.
module rmdq_sqrt_pipe #(
    parameter int unsigned RAD_W  = 64,
    parameter int unsigned SIDE_W = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [RAD_W-1:0]    in_rad,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output logic [RAD_W/2-1:0]  out_root,
    output logic [SIDE_W-1:0]   out_side
);
    import rmdq_pkg::*;

    localparam int unsigned STEPS  = RAD_W / 2;
    localparam int unsigned ROOT_W = STEPS;
    localparam int unsigned REM_W  = ROOT_W + 2;

    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sq_stage_t;

    logic [STEPS-1:0]  valid_reg;
    sq_stage_t         stage_reg  [STEPS];
    sq_stage_t         stage_next [STEPS];
    logic [SIDE_W-1:0] side_reg   [STEPS];
    sq_stage_t         first;

    // One restoring step: bring down two radicand bits and try the next root bit.
    function automatic sq_stage_t sqrt_step(input sq_stage_t cur);
        sq_stage_t        nxt;
        logic [REM_W+1:0] pair;
        logic [REM_W+1:0] trial;
        logic             ge;
        pair     = {cur.rem, cur.rad[RAD_W-1 -: 2]};
        trial    = (REM_W+2)'({cur.root, 2'b01});
        ge       = pair >= trial;
        nxt.rem  = ge ? REM_W'(pair - trial) : REM_W'(pair);
        nxt.root = {cur.root[ROOT_W-2:0], ge};
        nxt.rad  = cur.rad << 2;
        return nxt;
    endfunction

    assign first = '{rad: in_rad, rem: '0, root: '0};

    always_comb begin
        stage_next[0] = sqrt_step(first);
        for (int k = 1; k < STEPS; k++) begin
            stage_next[k] = sqrt_step(stage_reg[k-1]);
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= '0;
        end
        else if (en) begin
            valid_reg <= {valid_reg[STEPS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            side_reg[0] <= in_side;
            for (int k = 0; k < STEPS; k++) begin
                stage_reg[k] <= stage_next[k];
            end
            for (int k = 1; k < STEPS; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign out_root  = stage_reg[STEPS-1].root;
    assign out_side  = side_reg[STEPS-1];

endmodule

>>> rtl/rmdq_div_pipe.sv
// Pipelined restoring divider: lanes of (mag << 30) / den sharing one divisor.
module rmdq_div_pipe #(
    parameter int unsigned LANES  = 3,
    parameter int unsigned MAG_W  = 33,
    parameter int unsigned DEN_W  = 33,
    parameter int unsigned SIDE_W = 1
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          en,
    input  logic                                          in_valid,
    input  logic [LANES-1:0][MAG_W-1:0]                   in_mag,
    input  logic [DEN_W-1:0]                              in_den,
    input  logic [SIDE_W-1:0]                             in_side,
    output logic                                          out_valid,
    output logic [LANES-1:0][rmdq_pkg::WORD_W-1:0]        out_quot,
    output logic [SIDE_W-1:0]                             out_side
);
    import rmdq_pkg::*;

    // The top quotient bit flags a quotient of 2^31 or more.
    localparam int unsigned QUOT_W = WORD_W;
    localparam int unsigned STEPS  = QUOT_W;
    localparam int unsigned NUM_W  = MAG_W + FRAC_W;
    localparam int unsigned SHD_W  = DEN_W + QUOT_W - 1;
    localparam int unsigned REM_W  = ((NUM_W > SHD_W) ? NUM_W : SHD_W) + 1;

    typedef struct packed {
        logic [DEN_W-1:0]              den;
        logic [LANES-1:0][REM_W-1:0]   rem;
        logic [LANES-1:0][QUOT_W-1:0]  quot;
    } dv_stage_t;

    logic [STEPS-1:0]  valid_reg;
    dv_stage_t         stage_reg  [STEPS];
    dv_stage_t         stage_next [STEPS];
    logic [SIDE_W-1:0] side_reg   [STEPS];
    dv_stage_t         first;

    // One quotient bit per lane at bit position sh.
    function automatic dv_stage_t div_step(input dv_stage_t cur, input int unsigned sh);
        dv_stage_t        nxt;
        logic [REM_W-1:0] sub;
        logic             ge;
        nxt = cur;
        sub = REM_W'(cur.den) << sh;
        for (int l = 0; l < LANES; l++) begin
            ge          = cur.rem[l] >= sub;
            nxt.rem[l]  = ge ? (cur.rem[l] - sub) : cur.rem[l];
            nxt.quot[l] = {cur.quot[l][QUOT_W-2:0], ge};
        end
        return nxt;
    endfunction

    always_comb begin
        first.den  = in_den;
        first.quot = '0;
        for (int l = 0; l < LANES; l++) begin
            first.rem[l] = REM_W'(in_mag[l]) << FRAC_W;
        end
    end

    always_comb begin
        stage_next[0] = div_step(first, STEPS - 1);
        for (int k = 1; k < STEPS; k++) begin
            stage_next[k] = div_step(stage_reg[k-1], STEPS - 1 - k);
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= '0;
        end
        else if (en) begin
            valid_reg <= {valid_reg[STEPS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            side_reg[0] <= in_side;
            for (int k = 0; k < STEPS; k++) begin
                stage_reg[k] <= stage_next[k];
            end
            for (int k = 1; k < STEPS; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign out_quot  = stage_reg[STEPS-1].quot;
    assign out_side  = side_reg[STEPS-1];

endmodule

>>> rtl/rmdq_dual.sv
// Dual part: half of (t,0) times the real quaternion, rounded and saturated; output register.
module rmdq_dual (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  rmdq_pkg::word_t [3:0]             in_real,
    input  rmdq_pkg::trans_t                  in_trans,
    output logic                              out_valid,
    output rmdq_pkg::dquat_t                  out_data
);
    import rmdq_pkg::*;

    localparam int unsigned PROD_W     = 2 * WORD_W;
    localparam int unsigned ACC_W      = PROD_W + 2;
    localparam int unsigned DUAL_SHIFT = FRAC_W + 1;

    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [ACC_W-1:0]  acc_t;

    logic                    mul_valid_reg;
    prod_t [3:0][2:0]        prod_reg;
    prod_t [3:0][2:0]        prod_next;
    word_t [3:0]             real_reg;
    logic                    out_valid_reg;
    dquat_t                  out_reg;
    dquat_t                  out_next;
    word_t [3:0]             dual_val;

    function automatic prod_t smul(input word_t a, input word_t b);
        return prod_t'(a) * prod_t'(b);
    endfunction

    // Products; the sign pattern is applied when summing.
    always_comb begin
        prod_next[IDX_X] = {smul(in_trans.z, in_real[IDX_Y]),
                            smul(in_trans.y, in_real[IDX_Z]),
                            smul(in_real[IDX_W], in_trans.x)};
        prod_next[IDX_Y] = {smul(in_trans.x, in_real[IDX_Z]),
                            smul(in_trans.z, in_real[IDX_X]),
                            smul(in_real[IDX_W], in_trans.y)};
        prod_next[IDX_Z] = {smul(in_trans.y, in_real[IDX_X]),
                            smul(in_trans.x, in_real[IDX_Y]),
                            smul(in_real[IDX_W], in_trans.z)};
        prod_next[IDX_W] = {smul(in_trans.z, in_real[IDX_Z]),
                            smul(in_trans.y, in_real[IDX_Y]),
                            smul(in_trans.x, in_real[IDX_X])};
    end

    // Sum, divide by 2^31 rounding half up, saturate.
    always_comb begin
        acc_t acc;
        acc_t quo;
        for (int c = 0; c < 4; c++) begin
            if (c == IDX_W) begin
                acc = -(ACC_W'(prod_reg[c][0]) + ACC_W'(prod_reg[c][1])
                        + ACC_W'(prod_reg[c][2]));
            end
            else begin
                acc = ACC_W'(prod_reg[c][0]) + ACC_W'(prod_reg[c][1])
                    - ACC_W'(prod_reg[c][2]);
            end
            acc = acc + (acc_t'(1) <<< (DUAL_SHIFT - 1));
            quo = acc >>> DUAL_SHIFT;
            if (quo > ACC_W'(SAT_POS)) begin
                dual_val[c] = SAT_POS;
            end
            else if (quo < ACC_W'(SAT_NEG)) begin
                dual_val[c] = SAT_NEG;
            end
            else begin
                dual_val[c] = quo[WORD_W-1:0];
            end
        end
        out_next.real_x = real_reg[IDX_X];
        out_next.real_y = real_reg[IDX_Y];
        out_next.real_z = real_reg[IDX_Z];
        out_next.real_w = real_reg[IDX_W];
        out_next.dual_x = dual_val[IDX_X];
        out_next.dual_y = dual_val[IDX_Y];
        out_next.dual_z = dual_val[IDX_Z];
        out_next.dual_w = dual_val[IDX_W];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en) begin
            mul_valid_reg <= in_valid;
            out_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            prod_reg <= prod_next;
            real_reg <= in_real;
            out_reg  <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
